// ----- src/seb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seb_pkg
// Shared types, codes and default sizes of the stack bytecode executor.
// ----------------------------------------------------------------------------
package seb_pkg;

   localparam int STACK_DEPTH_DEF  = 256;
   localparam int LOCALS_DEPTH_DEF = 256;
   localparam int CALL_DEPTH_DEF   = 64;

   typedef enum logic [4:0] {
      OP_POP    = 5'd0,
      OP_DUP    = 5'd1,
      OP_SWAP   = 5'd2,
      OP_RETURN = 5'd3,
      OP_ADD    = 5'd4,
      OP_SUB    = 5'd5,
      OP_MUL    = 5'd6,
      OP_DIV    = 5'd7,
      OP_REM    = 5'd8,
      OP_AND    = 5'd9,
      OP_OR     = 5'd10,
      OP_XOR    = 5'd11,
      OP_SHL    = 5'd12,
      OP_SHR    = 5'd13,
      OP_BIPUSH = 5'd14,
      OP_ILDC   = 5'd15,
      OP_NULL   = 5'd16,
      OP_VLOAD  = 5'd17,
      OP_VSTORE = 5'd18,
      OP_NOP    = 5'd19,
      OP_CMPEQ  = 5'd20,
      OP_CMPNE  = 5'd21,
      OP_CMPLT  = 5'd22,
      OP_CMPGE  = 5'd23,
      OP_CMPGT  = 5'd24,
      OP_CMPLE  = 5'd25,
      OP_GOTO   = 5'd26,
      OP_THROW  = 5'd27,
      OP_ASSERT = 5'd28,
      OP_INVOKE = 5'd29
   } opcode_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_DIV_ZERO = 3'd1,
      ERR_OVERFLOW = 3'd2,
      ERR_SHIFT    = 3'd3,
      ERR_THROW    = 3'd4,
      ERR_ASSERT   = 3'd5,
      ERR_STACK    = 3'd6,
      ERR_DEPTH    = 3'd7
   } err_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_SWAP,
      ST_DIV,
      ST_CALL_RD,
      ST_CALL_WR,
      ST_TOS,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic accept_en;
      logic rd_en;
      logic exec_en;
      logic swap_en;
      logic div_start;
      logic div_commit;
      logic clr_step;
      logic call_rd;
      logic call_wr;
      logic tos_rd;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic req_fire;
      logic clr_last;
      logic need_div;
      logic need_swap;
      logic need_call;
      logic call_last;
      logic div_done;
      logic out_busy;
   } ctl_stat_type;

endpackage

`default_nettype wire

// ----- src/seb_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seb_if
// Valid/ready channels of the executor: instruction, result and register write.
// ----------------------------------------------------------------------------
interface seb_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  command;
   logic signed [15:0] immediate;
   logic signed [31:0] pool_value;
   logic [7:0]  callee_args;
   logic [7:0]  callee_vars;
   logic [15:0] callee_entry;

   modport source (output valid, command, immediate, pool_value, callee_args,
                   callee_vars, callee_entry, input ready);
   modport sink (input valid, command, immediate, pool_value, callee_args,
                 callee_vars, callee_entry, output ready);
endinterface

interface seb_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] next_pc;
   logic        finished;
   logic signed [31:0] return_value;
   logic [2:0]  error_code;
   logic signed [31:0] top_of_stack;

   modport source (output valid, next_pc, finished, return_value, error_code,
                   top_of_stack, input ready);
   modport sink (input valid, next_pc, finished, return_value, error_code,
                 top_of_stack, output ready);
endinterface

interface seb_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] main_locals;

   modport source (output valid, main_locals, input ready);
   modport sink (input valid, main_locals, output ready);
endinterface

`default_nettype wire

// ----- src/seb_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seb_div
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module seb_div
   import seb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient,
   output logic [31:0]      remainder
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] dvd_ff;
   logic [31:0] dvs_ff;
   logic [31:0] rem_ff;
   logic        negq_ff;
   logic        negr_ff;
   logic [32:0] shifted;
   logic [32:0] diff;

   assign shifted = {rem_ff, dvd_ff[31]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff  <= dividend[31] ? -dividend : dividend;
         dvs_ff  <= divisor[31] ? -divisor : divisor;
         rem_ff  <= '0;
         negq_ff <= dividend[31] ^ divisor[31];
         negr_ff <= dividend[31];
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_ff <= diff[31:0];
         end else begin
            rem_ff <= shifted[31:0];
         end
         dvd_ff <= {dvd_ff[30:0], ~diff[32]};
      end
   end

   assign done      = done_ff;
   assign quotient  = negq_ff ? -dvd_ff : dvd_ff;
   assign remainder = negr_ff ? -rem_ff : rem_ff;

endmodule

`default_nettype wire

// ----- src/seb_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seb_datapath
// Operand stack, locals and frame memories, machine registers and result beat.
// ----------------------------------------------------------------------------
module seb_datapath
   import seb_pkg::*;
#(
   parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
   parameter int LOCALS_DEPTH = LOCALS_DEPTH_DEF,
   parameter int CALL_DEPTH   = CALL_DEPTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  ctl_cmd_type cmd,
   output ctl_stat_type stat,
   seb_req_if.sink    req_ch,
   seb_rsp_if.source  rsp_ch,
   seb_csr_if.sink    csr_ch
);

   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int LAW = $clog2(LOCALS_DEPTH);
   localparam int LPW = $clog2(LOCALS_DEPTH + 1);
   localparam int CAW = $clog2(CALL_DEPTH);
   localparam int FDW = $clog2(CALL_DEPTH + 1);
   localparam int FRW = 16 + SPW + LPW + 8;

   logic [31:0]    stack_mem [STACK_DEPTH];
   logic [31:0]    locals_mem [LOCALS_DEPTH];
   logic [FRW-1:0] frame_mem [CALL_DEPTH];

   logic [4:0]  cmd_ff;
   logic [15:0] imm_ff;
   logic [31:0] pool_ff;
   logic [7:0]  nargs_ff;
   logic [7:0]  nvars_ff;
   logic [15:0] entry_ff;

   logic [31:0]    st_a_ff;
   logic [31:0]    st_b_ff;
   logic [31:0]    loc_rd_ff;
   logic [FRW-1:0] frm_rd_ff;

   logic [SPW-1:0] sp_ff;
   logic [SPW-1:0] fsb_ff;
   logic [LPW-1:0] lbase_ff;
   logic [7:0]     lcount_ff;
   logic [FDW-1:0] fd_ff;
   logic [15:0]    pc_ff;
   logic           halted_ff;
   logic           done_ff;
   err_type        ecode_ff;
   logic [31:0]    evalue_ff;
   logic [LAW-1:0] clr_ff;
   logic [7:0]     ci_ff;

   logic        rsp_valid_ff;
   logic [15:0] rsp_pc_ff;
   logic        rsp_fin_ff;
   logic [31:0] rsp_ret_ff;
   logic [2:0]  rsp_err_ff;
   logic [31:0] rsp_tos_ff;

   logic [SPW-1:0] sp_in;
   logic [SPW-1:0] fsb_in;
   logic [LPW-1:0] lbase_in;
   logic [7:0]     lcount_in;
   logic [FDW-1:0] fd_in;
   logic [15:0]    pc_in;
   logic           done_in;
   logic [31:0]    evalue_in;

   logic           flt;
   err_type        fcode;
   logic           need_div;
   logic           need_swap;
   logic           need_call;
   logic           e_stk_we;
   logic [SAW-1:0] e_stk_wa;
   logic [31:0]    e_stk_wd;
   logic           e_loc_we;
   logic           e_frm_we;

   logic           stk_we;
   logic [SAW-1:0] stk_wa;
   logic [31:0]    stk_wd;
   logic           loc_we;
   logic [LAW-1:0] loc_wa;
   logic [31:0]    loc_wd;
   logic [SAW-1:0] rb_addr;

   logic [SPW-1:0] sp_m1;
   logic [SPW-1:0] sp_m2;
   logic [SPW-1:0] sp_ci;
   logic [SPW-1:0] avail;
   logic [SPW-1:0] room;
   logic [16:0]    loc_sum;
   logic [LAW-1:0] loc_ix;
   logic [16:0]    call_sum;
   logic [LPW:0]   base_w;
   logic [7:0]     count_w;
   logic [FDW-1:0] fd_m1;
   logic [31:0]    a_v;
   logic [31:0]    b_v;
   logic [31:0]    alu_r;
   logic           shift_bad;
   logic [31:0]    div_q;
   logic [31:0]    div_r;
   logic           div_done;
   logic [7:0]     ml_cnt;
   logic           req_fire;
   logic           csr_fire;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign csr_fire = csr_ch.valid && csr_ch.ready;
   assign req_ch.ready = cmd.accept_en;
   assign csr_ch.ready = 1'b1;

   assign sp_m1    = sp_ff - SPW'(1);
   assign sp_m2    = sp_ff - SPW'(2);
   assign sp_ci    = sp_ff + SPW'(ci_ff);
   assign avail    = sp_ff - fsb_ff;
   assign room     = SPW'(STACK_DEPTH) - sp_ff;
   assign loc_sum  = 17'(lbase_ff) + {1'b0, imm_ff};
   assign loc_ix   = loc_sum[LAW-1:0];
   assign call_sum = 17'(lbase_ff) + 17'(ci_ff);
   assign base_w   = (LPW + 1)'(lbase_ff) + (LPW + 1)'(lcount_ff);
   assign count_w  = (nvars_ff > nargs_ff) ? nvars_ff : nargs_ff;
   assign fd_m1    = fd_ff - FDW'(1);
   assign a_v      = st_a_ff;
   assign b_v      = st_b_ff;
   assign shift_bad = (b_v[31:5] != '0);
   assign ml_cnt   = (32'(csr_ch.main_locals) > LOCALS_DEPTH) ? 8'(LOCALS_DEPTH)
                                                             : csr_ch.main_locals;

   seb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (st_a_ff),
      .divisor   (st_b_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      case (cmd_ff)
         OP_ADD:  alu_r = a_v + b_v;
         OP_SUB:  alu_r = a_v - b_v;
         OP_MUL:  alu_r = a_v * b_v;
         OP_AND:  alu_r = a_v & b_v;
         OP_OR:   alu_r = a_v | b_v;
         OP_XOR:  alu_r = a_v ^ b_v;
         OP_SHL:  alu_r = a_v << b_v[4:0];
         OP_SHR:  alu_r = $signed(a_v) >>> b_v[4:0];
         default: alu_r = '0;
      endcase
   end

   always_comb begin
      sp_in     = sp_ff;
      fsb_in    = fsb_ff;
      lbase_in  = lbase_ff;
      lcount_in = lcount_ff;
      fd_in     = fd_ff;
      pc_in     = pc_ff;
      done_in   = done_ff;
      evalue_in = evalue_ff;
      flt       = 1'b0;
      fcode     = ERR_NONE;
      need_div  = 1'b0;
      need_swap = 1'b0;
      need_call = 1'b0;
      e_stk_we  = 1'b0;
      e_stk_wa  = sp_ff[SAW-1:0];
      e_stk_wd  = b_v;
      e_loc_we  = 1'b0;
      e_frm_we  = 1'b0;
      if (!halted_ff) begin
         case (cmd_ff)
            OP_POP: begin
               if (avail < SPW'(1)) begin
                  flt = 1'b1; fcode = ERR_STACK;
               end else begin
                  sp_in = sp_m1;
                  pc_in = pc_ff + 16'd1;
               end
            end
            OP_DUP: begin
               if (avail < SPW'(1) || room < SPW'(1)) begin
                  flt = 1'b1; fcode = ERR_STACK;
               end else begin
                  e_stk_we = 1'b1;
                  sp_in    = sp_ff + SPW'(1);
                  pc_in    = pc_ff + 16'd1;
               end
            end
            OP_SWAP: begin
               if (avail < SPW'(2)) begin
                  flt = 1'b1; fcode = ERR_STACK;
               end else begin
                  e_stk_we  = 1'b1;
                  e_stk_wa  = sp_m1[SAW-1:0];
                  e_stk_wd  = a_v;
                  need_swap = 1'b1;
                  pc_in     = pc_ff + 16'd1;
               end
            end
            OP_RETURN: begin
               if (avail != SPW'(1)) begin
                  flt = 1'b1; fcode = ERR_STACK;
               end else if (fd_ff == '0) begin
                  sp_in     = sp_m1;
                  done_in   = 1'b1;
                  evalue_in = b_v;
               end else begin
                  fd_in     = fd_m1;
                  sp_in     = fsb_ff + SPW'(1);
                  pc_in     = frm_rd_ff[FRW-1 -: 16];
                  fsb_in    = frm_rd_ff[SPW+LPW+7 -: SPW];
                  lbase_in  = frm_rd_ff[LPW+7 -: LPW];
                  lcount_in = frm_rd_ff[7:0];
                  e_stk_we  = 1'b1;
                  e_stk_wa  = fsb_ff[SAW-1:0];
               end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR: begin
               if (avail < SPW'(2)) begin
                  flt = 1'b1; fcode = ERR_STACK;
               end else if ((cmd_ff == OP_SHL || cmd_ff == OP_SHR) && shift_bad) begin
                  flt = 1'b1; fcode = ERR_SHIFT;
               end else begin
                  e_stk_we = 1'b1;
                  e_stk_wa = sp_m2[SAW-1:0];
                  e_stk_wd = alu_r;
                  sp_in    = sp_m1;
                  pc_in    = pc_ff + 16'd1;
               end
            end
            OP_DIV, OP_REM: begin
               if (avail < SPW'(2)) begin
                  flt = 1'b1; fcode = ERR_STACK;
               end else if (b_v == '0) begin
                  flt = 1'b1; fcode = ERR_DIV_ZERO;
               end else if (a_v == 32'h8000_0000 && b_v == 32'hFFFF_FFFF) begin
                  flt = 1'b1; fcode = ERR_OVERFLOW;
               end else begin
                  need_div = 1'b1;
               end
            end
            OP_BIPUSH, OP_ILDC, OP_NULL: begin
               if (room < SPW'(1)) begin
                  flt = 1'b1; fcode = ERR_STACK;
               end else begin
                  e_stk_we = 1'b1;
                  sp_in    = sp_ff + SPW'(1);
                  if (cmd_ff == OP_BIPUSH) begin
                     e_stk_wd = {{24{imm_ff[7]}}, imm_ff[7:0]};
                     pc_in    = pc_ff + 16'd2;
                  end else if (cmd_ff == OP_ILDC) begin
                     e_stk_wd = pool_ff;
                     pc_in    = pc_ff + 16'd3;
                  end else begin
                     e_stk_wd = '0;
                     pc_in    = pc_ff + 16'd1;
                  end
               end
            end
            OP_VLOAD: begin
               if (imm_ff >= 16'(lcount_ff) || room < SPW'(1)) begin
                  flt = 1'b1; fcode = ERR_STACK;
               end else begin
                  e_stk_we = 1'b1;
                  e_stk_wd = loc_rd_ff;
                  sp_in    = sp_ff + SPW'(1);
                  pc_in    = pc_ff + 16'd2;
               end
            end
            OP_VSTORE: begin
               if (imm_ff >= 16'(lcount_ff) || avail < SPW'(1)) begin
                  flt = 1'b1; fcode = ERR_STACK;
               end else begin
                  e_loc_we = 1'b1;
                  sp_in    = sp_m1;
                  pc_in    = pc_ff + 16'd2;
               end
            end
            OP_CMPEQ, OP_CMPNE, OP_CMPLT, OP_CMPGE, OP_CMPGT, OP_CMPLE: begin
               if (avail < SPW'(2)) begin
                  flt = 1'b1; fcode = ERR_STACK;
               end else begin
                  sp_in = sp_m2;
                  pc_in = pc_ff + 16'd3;
                  if ((cmd_ff == OP_CMPEQ && a_v == b_v) ||
                      (cmd_ff == OP_CMPNE && a_v != b_v) ||
                      (cmd_ff == OP_CMPLT && $signed(a_v) < $signed(b_v)) ||
                      (cmd_ff == OP_CMPGE && $signed(a_v) >= $signed(b_v)) ||
                      (cmd_ff == OP_CMPGT && $signed(a_v) > $signed(b_v)) ||
                      (cmd_ff == OP_CMPLE && $signed(a_v) <= $signed(b_v))) begin
                     pc_in = pc_ff + imm_ff;
                  end
               end
            end
            OP_GOTO: pc_in = pc_ff + imm_ff;
            OP_THROW: begin
               flt   = 1'b1;
               fcode = (avail < SPW'(1)) ? ERR_STACK : ERR_THROW;
            end
            OP_ASSERT: begin
               if (avail < SPW'(2)) begin
                  flt = 1'b1; fcode = ERR_STACK;
               end else if (a_v == '0) begin
                  flt = 1'b1; fcode = ERR_ASSERT;
               end else begin
                  sp_in = sp_m2;
                  pc_in = pc_ff + 16'd1;
               end
            end
            OP_INVOKE: begin
               if (32'(avail) < 32'(nargs_ff)) begin
                  flt = 1'b1; fcode = ERR_STACK;
               end else if (32'(fd_ff) >= CALL_DEPTH || 32'(base_w) > LOCALS_DEPTH ||
                            32'(count_w) > LOCALS_DEPTH - 32'(base_w)) begin
                  flt = 1'b1; fcode = ERR_DEPTH;
               end else begin
                  e_frm_we  = 1'b1;
                  fd_in     = fd_ff + FDW'(1);
                  sp_in     = sp_ff - SPW'(nargs_ff);
                  fsb_in    = sp_ff - SPW'(nargs_ff);
                  lbase_in  = base_w[LPW-1:0];
                  lcount_in = count_w;
                  pc_in     = entry_ff;
                  need_call = (count_w != '0);
               end
            end
            default: pc_in = pc_ff + 16'd1;
         endcase
      end
   end

   always_comb begin
      stk_we = 1'b0;
      stk_wa = e_stk_wa;
      stk_wd = e_stk_wd;
      if (cmd.exec_en) begin
         stk_we = e_stk_we && !flt;
      end else if (cmd.swap_en) begin
         stk_we = 1'b1;
         stk_wa = sp_m2[SAW-1:0];
         stk_wd = b_v;
      end else if (cmd.div_commit) begin
         stk_we = 1'b1;
         stk_wa = sp_m2[SAW-1:0];
         stk_wd = (cmd_ff == OP_DIV) ? div_q : div_r;
      end
      loc_we = 1'b0;
      loc_wa = loc_ix;
      loc_wd = b_v;
      if (cmd.clr_step) begin
         loc_we = 1'b1;
         loc_wa = clr_ff;
         loc_wd = '0;
      end else if (cmd.exec_en) begin
         loc_we = e_loc_we && !flt;
      end else if (cmd.call_wr) begin
         loc_we = 1'b1;
         loc_wa = call_sum[LAW-1:0];
         loc_wd = (ci_ff < nargs_ff) ? b_v : '0;
      end
      if (cmd.call_rd) begin
         rb_addr = sp_ci[SAW-1:0];
      end else begin
         rb_addr = sp_m1[SAW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_wa] <= stk_wd;
      end
      if (cmd.rd_en) begin
         st_a_ff <= stack_mem[sp_m2[SAW-1:0]];
      end
      if (cmd.rd_en || cmd.call_rd || cmd.tos_rd) begin
         st_b_ff <= stack_mem[rb_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (loc_we) begin
         locals_mem[loc_wa] <= loc_wd;
      end
      if (cmd.rd_en) begin
         loc_rd_ff <= locals_mem[loc_ix];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec_en && e_frm_we && !flt) begin
         frame_mem[fd_ff[CAW-1:0]] <= {pc_ff + 16'd3, fsb_ff, lbase_ff, lcount_ff};
      end
      if (cmd.rd_en) begin
         frm_rd_ff <= frame_mem[fd_m1[CAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_ch.command;
         imm_ff   <= req_ch.immediate;
         pool_ff  <= req_ch.pool_value;
         nargs_ff <= req_ch.callee_args;
         nvars_ff <= req_ch.callee_vars;
         entry_ff <= req_ch.callee_entry;
      end
      if (cmd.exec_en) begin
         ci_ff <= '0;
      end else if (cmd.call_wr) begin
         ci_ff <= ci_ff + 8'd1;
      end
      if (cmd.exec_en && done_in && !done_ff) begin
         evalue_ff <= evalue_in;
      end
      if (cmd.out_load) begin
         rsp_pc_ff  <= pc_ff;
         rsp_fin_ff <= halted_ff && done_ff;
         rsp_ret_ff <= (halted_ff && done_ff) ? evalue_ff : '0;
         rsp_err_ff <= halted_ff ? ecode_ff : ERR_NONE;
         rsp_tos_ff <= (sp_ff > fsb_ff) ? st_b_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         fsb_ff       <= '0;
         lbase_ff     <= '0;
         lcount_ff    <= '0;
         fd_ff        <= '0;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         done_ff      <= 1'b0;
         ecode_ff     <= ERR_NONE;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + LAW'(1);
         end
         if (cmd.exec_en) begin
            if (flt) begin
               halted_ff <= 1'b1;
               ecode_ff  <= fcode;
            end else begin
               sp_ff     <= sp_in;
               fsb_ff    <= fsb_in;
               lbase_ff  <= lbase_in;
               lcount_ff <= lcount_in;
               fd_ff     <= fd_in;
               pc_ff     <= pc_in;
               done_ff   <= done_in;
               if (done_in && !done_ff) begin
                  halted_ff <= 1'b1;
                  ecode_ff  <= ERR_NONE;
               end
            end
         end else if (cmd.div_commit) begin
            sp_ff <= sp_m1;
            pc_ff <= pc_ff + 16'd1;
         end
         if (csr_fire && fd_ff == '0) begin
            lcount_ff <= ml_cnt;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.next_pc      = rsp_pc_ff;
   assign rsp_ch.finished     = rsp_fin_ff;
   assign rsp_ch.return_value = rsp_ret_ff;
   assign rsp_ch.error_code   = rsp_err_ff;
   assign rsp_ch.top_of_stack = rsp_tos_ff;

   assign stat.req_fire  = req_fire;
   assign stat.clr_last  = (clr_ff == LAW'(LOCALS_DEPTH - 1));
   assign stat.need_div  = need_div;
   assign stat.need_swap = need_swap;
   assign stat.need_call = need_call;
   assign stat.call_last = (9'(ci_ff) + 9'd1 == 9'(lcount_ff));
   assign stat.div_done  = div_done;
   assign stat.out_busy  = rsp_valid_ff && !rsp_ch.ready;

   a_frame_below_sp: assert property (@(posedge clock) disable iff (reset)
      fsb_ff <= sp_ff)
      else $error("frame stack base above stack pointer");

   a_locals_fit: assert property (@(posedge clock) disable iff (reset)
      32'(lbase_ff) + 32'(lcount_ff) <= LOCALS_DEPTH)
      else $error("frame locals exceed locals store");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt released without reset");

   a_main_frame: assert property (@(posedge clock) disable iff (reset)
      (fd_ff == '0) |-> (fsb_ff == '0 && lbase_ff == '0))
      else $error("entry frame bases not at zero");

endmodule

`default_nettype wire

// ----- src/seb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seb_ctrl
// Instruction sequencer: clear, fetch operands, execute, extra steps, result.
// ----------------------------------------------------------------------------
module seb_ctrl
   import seb_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  ctl_stat_type stat,
   output ctl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.accept_en = 1'b1;
            if (stat.req_fire) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec_en = 1'b1;
            if (stat.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else if (stat.need_swap) begin
               state_in = ST_SWAP;
            end else if (stat.need_call) begin
               state_in = ST_CALL_RD;
            end else begin
               state_in = ST_TOS;
            end
         end
         ST_SWAP: begin
            cmd.swap_en = 1'b1;
            state_in    = ST_TOS;
         end
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.div_commit = 1'b1;
               state_in       = ST_TOS;
            end
         end
         ST_CALL_RD: begin
            cmd.call_rd = 1'b1;
            state_in    = ST_CALL_WR;
         end
         ST_CALL_WR: begin
            cmd.call_wr = 1'b1;
            state_in    = stat.call_last ? ST_TOS : ST_CALL_RD;
         end
         ST_TOS: begin
            cmd.tos_rd = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ----- src/stack_bytecode_executor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_bytecode_executor
// 32-bit integer stack machine, one decoded instruction per request beat.
// ----------------------------------------------------------------------------
// After reset the block sweeps the locals store to zero, one entry a cycle, before it
// takes the first request; register writes are taken at any time. Each request runs
// to completion before the next is taken: most instructions pass through accept,
// memory read, execute, top-of-stack read and result load; swap adds a second stack
// write, div and rem wait on the divider, which yields one quotient bit a cycle, and
// invokestatic adds, for each callee local, a read of the operand stack into a
// register and a write to the locals store that copies an argument or clears the
// local. A new request is taken while the previous result still waits on the
// response channel.
// ----------------------------------------------------------------------------
module stack_bytecode_executor
   import seb_pkg::*;
#(
   parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
   parameter int LOCALS_DEPTH = LOCALS_DEPTH_DEF,
   parameter int CALL_DEPTH   = CALL_DEPTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   seb_req_if.sink   req_ch,
   seb_rsp_if.source rsp_ch,
   seb_csr_if.sink   csr_ch
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   seb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   seb_datapath #(
      .STACK_DEPTH  (STACK_DEPTH),
      .LOCALS_DEPTH (LOCALS_DEPTH),
      .CALL_DEPTH   (CALL_DEPTH)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .stat   (stat),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

endmodule

`default_nettype wire

// ----- bench/seb_exec_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seb_exec_checker
// Watches the instruction, result and register-write channels of the stack
// bytecode executor, runs each accepted instruction on its own model of the
// machine and compares every result beat field by field, in order.
// ----------------------------------------------------------------------------
module seb_exec_checker
   import seb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   seb_req_if   req_mon,
   seb_rsp_if   rsp_mon,
   seb_csr_if   csr_mon,
   output int   fail_count,
   output int   pending
);

   typedef struct {
      logic [15:0] next_pc;
      logic        finished;
      logic [31:0] return_value;
      logic [2:0]  error_code;
      logic [31:0] top_of_stack;
   } machine_status_t;

   machine_status_t due_q[$];

   logic [31:0] opnd_mem [256];
   logic [31:0] local_mem [256];
   logic [15:0] frm_ret [64];
   int          frm_sbase [64];
   int          frm_lbase [64];
   int          frm_lcnt [64];
   int          sp, sbase, lbase, lcnt, depth;
   logic [7:0]  main_locals;
   logic [15:0] pc;
   logic        halted, done;
   logic [2:0]  exit_code;
   logic [31:0] exit_value;

   initial fail_count = 0;
   initial pending = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      begin
         $display("[%0t] result beat: %s got %h want %h", $time, what, got, want);
         fail_count++;
      end
   endtask

   function automatic void clear_machine();
      for (int i = 0; i < 256; i++) begin
         opnd_mem[i] = '0;
         local_mem[i] = '0;
      end
      sp = 0; sbase = 0; lbase = 0; lcnt = 0; depth = 0;
      main_locals = '0;
      pc = '0;
      halted = 1'b0; done = 1'b0;
      exit_code = ERR_NONE; exit_value = '0;
   endfunction

   function automatic void halt_with(input logic [2:0] code);
      halted = 1'b1;
      exit_code = code;
   endfunction

   function automatic void advance_pc(input logic [15:0] n);
      pc = pc + n;
   endfunction

   function automatic machine_status_t status_now();
      machine_status_t s;
      s.next_pc = pc;
      s.finished = halted && done;
      s.return_value = (halted && done) ? exit_value : 32'd0;
      s.error_code = halted ? exit_code : ERR_NONE;
      s.top_of_stack = (sp > sbase && sp <= 256) ? opnd_mem[sp - 1] : 32'd0;
      return s;
   endfunction

   function automatic void execute_instr(input logic [4:0] cmd, input logic [15:0] imm,
                                         input logic [31:0] pool, input logic [7:0] nargs,
                                         input logic [7:0] nvars, input logic [15:0] entry);
      int avail, room, idx, cnt, base;
      logic [31:0] a, b, r;
      logic [2:0] e;
      logic taken;
      if (halted) return;
      avail = sp - sbase;
      room = 256 - sp;
      idx = int'(imm);
      case (cmd)
         OP_POP: begin
            if (avail < 1) halt_with(ERR_STACK);
            else begin
               sp--;
               advance_pc(1);
            end
         end
         OP_DUP: begin
            if (avail < 1 || room < 1) halt_with(ERR_STACK);
            else begin
               opnd_mem[sp] = opnd_mem[sp - 1];
               sp++;
               advance_pc(1);
            end
         end
         OP_SWAP: begin
            if (avail < 2) halt_with(ERR_STACK);
            else begin
               r = opnd_mem[sp - 1];
               opnd_mem[sp - 1] = opnd_mem[sp - 2];
               opnd_mem[sp - 2] = r;
               advance_pc(1);
            end
         end
         OP_RETURN: begin
            if (avail != 1) halt_with(ERR_STACK);
            else begin
               r = opnd_mem[sp - 1];
               if (depth == 0) begin
                  sp--;
                  halted = 1'b1;
                  done = 1'b1;
                  exit_value = r;
                  exit_code = ERR_NONE;
               end else begin
                  depth--;
                  sp = sbase;
                  pc = frm_ret[depth];
                  sbase = frm_sbase[depth];
                  lbase = frm_lbase[depth];
                  lcnt = frm_lcnt[depth];
                  opnd_mem[sp] = r;
                  sp++;
               end
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR: begin
            if (avail < 2) halt_with(ERR_STACK);
            else begin
               a = opnd_mem[sp - 2];
               b = opnd_mem[sp - 1];
               e = ERR_NONE;
               r = '0;
               case (cmd)
                  OP_ADD: r = a + b;
                  OP_SUB: r = a - b;
                  OP_MUL: r = a * b;
                  OP_AND: r = a & b;
                  OP_OR:  r = a | b;
                  OP_XOR: r = a ^ b;
                  OP_DIV, OP_REM: begin
                     if (b == 32'd0) e = ERR_DIV_ZERO;
                     else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) e = ERR_OVERFLOW;
                     else if (cmd == OP_DIV) r = $signed(a) / $signed(b);
                     else r = $signed(a) % $signed(b);
                  end
                  default: begin
                     if ($signed(b) < 0 || $signed(b) > 31) e = ERR_SHIFT;
                     else if (cmd == OP_SHL) r = a << b[4:0];
                     else r = $signed(a) >>> b[4:0];
                  end
               endcase
               if (e != ERR_NONE) halt_with(e);
               else begin
                  sp--;
                  opnd_mem[sp - 1] = r;
                  advance_pc(1);
               end
            end
         end
         OP_BIPUSH, OP_ILDC, OP_NULL: begin
            if (room < 1) halt_with(ERR_STACK);
            else begin
               if (cmd == OP_BIPUSH) r = {{24{imm[7]}}, imm[7:0]};
               else if (cmd == OP_ILDC) r = pool;
               else r = '0;
               opnd_mem[sp] = r;
               sp++;
               advance_pc(cmd == OP_BIPUSH ? 16'd2 : (cmd == OP_ILDC ? 16'd3 : 16'd1));
            end
         end
         OP_VLOAD: begin
            if (idx >= lcnt || room < 1) halt_with(ERR_STACK);
            else begin
               opnd_mem[sp] = local_mem[lbase + idx];
               sp++;
               advance_pc(2);
            end
         end
         OP_VSTORE: begin
            if (idx >= lcnt || avail < 1) halt_with(ERR_STACK);
            else begin
               sp--;
               local_mem[lbase + idx] = opnd_mem[sp];
               advance_pc(2);
            end
         end
         OP_CMPEQ, OP_CMPNE, OP_CMPLT, OP_CMPGE, OP_CMPGT, OP_CMPLE: begin
            if (avail < 2) halt_with(ERR_STACK);
            else begin
               a = opnd_mem[sp - 2];
               b = opnd_mem[sp - 1];
               case (cmd)
                  OP_CMPEQ: taken = (a == b);
                  OP_CMPNE: taken = (a != b);
                  OP_CMPLT: taken = ($signed(a) < $signed(b));
                  OP_CMPGE: taken = ($signed(a) >= $signed(b));
                  OP_CMPGT: taken = ($signed(a) > $signed(b));
                  default:  taken = ($signed(a) <= $signed(b));
               endcase
               advance_pc(taken ? imm : 16'd3);
               sp -= 2;
            end
         end
         OP_GOTO: advance_pc(imm);
         OP_THROW: begin
            if (avail < 1) halt_with(ERR_STACK);
            else halt_with(ERR_THROW);
         end
         OP_ASSERT: begin
            if (avail < 2) halt_with(ERR_STACK);
            else if (opnd_mem[sp - 2] == 32'd0) halt_with(ERR_ASSERT);
            else begin
               sp -= 2;
               advance_pc(1);
            end
         end
         OP_INVOKE: begin
            cnt = (nvars > nargs) ? int'(nvars) : int'(nargs);
            base = lbase + lcnt;
            if (avail < int'(nargs)) halt_with(ERR_STACK);
            else if (depth >= 64 || base > 256 || cnt > 256 - base) halt_with(ERR_DEPTH);
            else begin
               frm_ret[depth] = pc + 16'd3;
               frm_sbase[depth] = sbase;
               frm_lbase[depth] = lbase;
               frm_lcnt[depth] = lcnt;
               depth++;
               for (int i = 0; i < cnt; i++) local_mem[base + i] = '0;
               for (int i = 0; i < int'(nargs); i++)
                  local_mem[base + i] = opnd_mem[sp - int'(nargs) + i];
               sp -= int'(nargs);
               sbase = sp;
               lbase = base;
               lcnt = cnt;
               pc = entry;
            end
         end
         default: advance_pc(1);
      endcase
   endfunction

   always @(posedge clock) begin
      machine_status_t want;
      if (reset) begin
         clear_machine();
         due_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_q.size() == 0) begin
               report("unexpected beat", {16'd0, rsp_mon.next_pc}, 32'd0);
            end else begin
               want = due_q.pop_front();
               if (rsp_mon.next_pc !== want.next_pc)
                  report("next_pc", rsp_mon.next_pc, want.next_pc);
               if (rsp_mon.finished !== want.finished)
                  report("finished", rsp_mon.finished, want.finished);
               if (rsp_mon.return_value !== want.return_value)
                  report("return_value", rsp_mon.return_value, want.return_value);
               if (rsp_mon.error_code !== want.error_code)
                  report("error_code", rsp_mon.error_code, want.error_code);
               if (rsp_mon.top_of_stack !== want.top_of_stack)
                  report("top_of_stack", rsp_mon.top_of_stack, want.top_of_stack);
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            main_locals = csr_mon.main_locals;
            if (depth == 0) lcnt = int'(main_locals);
         end
         if (req_mon.valid && req_mon.ready) begin
            execute_instr(req_mon.command, req_mon.immediate, req_mon.pool_value,
                          req_mon.callee_args, req_mon.callee_vars, req_mon.callee_entry);
            due_q.push_back(status_now());
         end
      end
      pending = due_q.size();
   end

endmodule

// ----- bench/stack_bytecode_executor_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_bytecode_executor_tb
// Drives well-formed instruction streams with random content into the stack
// bytecode executor under three idle mixes, a long result stall and several
// main_locals settings, then ends the program with one randomly chosen fault
// or a clean return and checks that the halt status repeats.
// ----------------------------------------------------------------------------
module stack_bytecode_executor_tb;
   import seb_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycle_count = 0;
   int   snd_idle = 0;
   int   rsp_idle = 0;
   int   stall_left = 0;
   int   beats_sent = 0;
   int   end_kind;
   bit   track = 1'b1;

   // stimulus-side view of the stack and frame layout
   int sp = 0, sbase = 0, lbase = 0, lcnt = 0, depth = 0;
   int frm_sbase [65];
   int frm_lbase [65];
   int frm_lcnt [65];

   seb_req_if req_ch ();
   seb_rsp_if rsp_ch ();
   seb_csr_if csr_ch ();

   stack_bytecode_executor dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   seb_exec_checker exec_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_mon    (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle);
         end
      end
   end

   task automatic issue(input logic [4:0] cmd, input logic [15:0] imm, input logic [31:0] pool,
                        input logic [7:0] nargs, input logic [7:0] nvars,
                        input logic [15:0] entry);
      int cnt;
      begin
         @(negedge clock);
         while ($urandom_range(99) < snd_idle) begin
            req_ch.valid <= 1'b0;
            @(negedge clock);
         end
         req_ch.valid <= 1'b1;
         req_ch.command <= cmd;
         req_ch.immediate <= imm;
         req_ch.pool_value <= pool;
         req_ch.callee_args <= nargs;
         req_ch.callee_vars <= nvars;
         req_ch.callee_entry <= entry;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         beats_sent++;
         if (track) begin
            case (cmd)
               OP_POP, OP_VSTORE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_AND, OP_OR,
               OP_XOR, OP_SHL, OP_SHR: sp--;
               OP_DUP, OP_BIPUSH, OP_ILDC, OP_NULL, OP_VLOAD: sp++;
               OP_CMPEQ, OP_CMPNE, OP_CMPLT, OP_CMPGE, OP_CMPGT, OP_CMPLE, OP_ASSERT: sp -= 2;
               OP_RETURN: begin
                  depth--;
                  sp = sbase + 1;
                  sbase = frm_sbase[depth];
                  lbase = frm_lbase[depth];
                  lcnt = frm_lcnt[depth];
               end
               OP_INVOKE: begin
                  cnt = (nvars > nargs) ? int'(nvars) : int'(nargs);
                  frm_sbase[depth] = sbase;
                  frm_lbase[depth] = lbase;
                  frm_lcnt[depth] = lcnt;
                  depth++;
                  sp -= int'(nargs);
                  sbase = sp;
                  lbase = lbase + lcnt;
                  lcnt = cnt;
               end
               default: ;
            endcase
         end
      end
   endtask

   task automatic op(input logic [4:0] cmd, input logic [15:0] imm);
      issue(cmd, imm, $urandom, 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic push_word(input logic [31:0] value);
      issue(OP_ILDC, 16'($urandom), value, 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic push_byte(input logic [7:0] value);
      op(OP_BIPUSH, {8'($urandom), value});
   endtask

   task automatic push_any();
      case ($urandom_range(2))
         0: push_byte(8'($urandom));
         1: push_word($urandom);
         default: op(OP_NULL, 16'($urandom));
      endcase
   endtask

   task automatic call(input logic [7:0] nargs, input logic [7:0] nvars);
      issue(OP_INVOKE, 16'($urandom), $urandom, nargs, nvars, 16'($urandom));
   endtask

   task automatic leave_frame();
      begin
         while (sp - sbase > 1) op(OP_POP, 16'($urandom));
         if (sp == sbase) push_any();
         op(OP_RETURN, 16'($urandom));
      end
   endtask

   task automatic csr_write(input logic [7:0] value);
      begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         while (pending != 0) @(negedge clock);
         @(negedge clock);
         csr_ch.valid <= 1'b1;
         csr_ch.main_locals <= value;
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
         @(negedge clock);
         csr_ch.valid <= 1'b0;
         if (depth == 0) lcnt = int'(value);
      end
   endtask

   task automatic random_step();
      int pick, avail, na, nv, cnt;
      logic [31:0] x, y;
      begin
         avail = sp - sbase;
         pick = $urandom_range(99);
         if (sp >= 236) begin
            if (avail > 0) op(OP_POP, 16'($urandom));
            else if (depth > 0) leave_frame();
            else op(OP_NOP, 16'($urandom));
         end else if (pick < 14) begin
            push_any();
         end else if (pick < 20) begin
            if (avail >= 1) op(OP_POP, 16'($urandom));
            else push_any();
         end else if (pick < 26) begin
            if (avail >= 1) op(OP_DUP, 16'($urandom));
            else push_any();
         end else if (pick < 31) begin
            if (avail >= 2) op(OP_SWAP, 16'($urandom));
            else push_any();
         end else if (pick < 46) begin
            if (avail >= 2) begin
               case ($urandom_range(5))
                  0: op(OP_ADD, 16'($urandom));
                  1: op(OP_SUB, 16'($urandom));
                  2: op(OP_MUL, 16'($urandom));
                  3: op(OP_AND, 16'($urandom));
                  4: op(OP_OR, 16'($urandom));
                  default: op(OP_XOR, 16'($urandom));
               endcase
            end else push_any();
         end else if (pick < 54) begin
            x = ($urandom_range(7) == 0) ? 32'h8000_0000 : $urandom;
            y = $urandom_range(1) ? $urandom : ($urandom_range(1) ? $urandom_range(1, 20)
                                                : -$urandom_range(1, 20));
            if (y == 32'd0) y = 32'd3;
            if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) y = 32'd1;
            push_word(x);
            push_word(y);
            op($urandom_range(1) ? OP_DIV : OP_REM, 16'($urandom));
         end else if (pick < 60) begin
            push_word($urandom);
            push_byte(8'($urandom_range(31)));
            op($urandom_range(1) ? OP_SHL : OP_SHR, 16'($urandom));
         end else if (pick < 68) begin
            if (avail >= 2) op(5'(OP_CMPEQ + $urandom_range(5)), 16'($urandom));
            else push_any();
         end else if (pick < 73) begin
            case ($urandom_range(3))
               0: op(OP_GOTO, 16'($urandom));
               1: op(OP_NOP, 16'($urandom));
               default: op(5'($urandom_range(30, 31)), 16'($urandom));
            endcase
         end else if (pick < 82) begin
            if (lcnt == 0) op(OP_NOP, 16'($urandom));
            else if (avail >= 1 && $urandom_range(1))
               op(OP_VSTORE, 16'($urandom_range(lcnt - 1)));
            else op(OP_VLOAD, 16'($urandom_range(lcnt - 1)));
         end else if (pick < 86) begin
            push_word($urandom | 32'd1);
            push_any();
            op(OP_ASSERT, 16'($urandom));
         end else if (pick < 93) begin
            na = $urandom_range((avail < 3) ? avail : 3);
            nv = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
            cnt = (nv > na) ? nv : na;
            if (depth < 64 && lbase + lcnt + cnt <= 256) call(8'(na), 8'(nv));
            else push_any();
         end else begin
            if (depth > 0) leave_frame();
            else op(OP_NOP, 16'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.command = OP_NOP;
      req_ch.immediate = '0;
      req_ch.pool_value = '0;
      req_ch.callee_args = '0;
      req_ch.callee_vars = '0;
      req_ch.callee_entry = '0;
      csr_ch.valid = 1'b0;
      csr_ch.main_locals = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_write(8'd4);
      push_byte(8'h7F);
      op(OP_BIPUSH, 16'hFF80);
      op(OP_ADD, 16'h0000);
      push_word(32'h8000_0000);
      push_word(32'h7FFF_FFFF);
      op(OP_SUB, 16'hFFFF);
      op(OP_MUL, 16'h0000);
      op(OP_DUP, 16'h0000);
      op(OP_SWAP, 16'h0000);
      op(OP_NULL, 16'h0000);
      op(OP_VSTORE, 16'd3);
      op(OP_VLOAD, 16'd3);
      op(OP_VLOAD, 16'd0);
      op(OP_CMPEQ, 16'h8000);
      op(OP_GOTO, 16'h7FFF);
      op(5'd30, 16'h0000);
      op(5'd31, 16'hFFFF);
      push_word(32'h8000_0000);
      push_byte(8'hF9);
      op(OP_DIV, 16'h0000);
      push_byte(8'd31);
      op(OP_SHL, 16'h0000);
      push_byte(8'd31);
      op(OP_SHR, 16'h0000);
      issue(OP_INVOKE, 16'h0000, 32'h0, 8'd1, 8'd3, 16'hFFFF);
      leave_frame();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin snd_idle = 11; rsp_idle = 75; end
            1: begin snd_idle = 75; rsp_idle = 11; end
            default: begin snd_idle = 0; rsp_idle = 0; end
         endcase
         csr_write(phase == 0 ? 8'd255 : (phase == 1 ? 8'd0 : 8'($urandom_range(1, 64))));
         for (int n = 0; n < 420; n++) begin
            if (phase == 2 && n == 200) stall_left = 300;
            random_step();
         end
      end

      // end the program: one fault or a clean return, then the halt must persist
      end_kind = $urandom_range(9);
      case (end_kind)
         0: begin push_byte(8'd5); push_byte(8'd0); op(OP_DIV, 16'h0); end
         1: begin
            push_word(32'h8000_0000); push_byte(8'hFF);
            op($urandom_range(1) ? OP_DIV : OP_REM, 16'h0);
         end
         2: begin
            push_byte(8'd5); push_byte($urandom_range(1) ? 8'd32 : 8'hFF);
            op($urandom_range(1) ? OP_SHL : OP_SHR, 16'h0);
         end
         3: begin push_any(); op(OP_THROW, 16'h0); end
         4: begin op(OP_NULL, 16'h0); push_byte(8'd1); op(OP_ASSERT, 16'h0); end
         5: begin
            while (sp > sbase) op(OP_POP, 16'($urandom));
            op(OP_POP, 16'h0);
         end
         6: op(OP_VLOAD, $urandom_range(1) ? 16'(lcnt) : 16'hFFFF);
         7: begin
            push_any(); push_any();
            op(OP_RETURN, 16'h0);
         end
         8: begin
            while (depth < 64) call(8'd0, 8'd0);
            call(8'd0, 8'd0);
         end
         default: begin
            while (depth > 0) leave_frame();
            leave_frame();
         end
      endcase
      track = 1'b0;
      repeat (8) issue(5'($urandom), 16'($urandom), $urandom, 8'($urandom),
                       8'($urandom), 16'($urandom));
      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (60) @(posedge clock);
      $display("%0d instruction beats over three idle mixes, a 300-cycle result stall and",
               beats_sent);
      $display("four main_locals settings; program ended by scenario %0d", end_kind);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
